// ----- design/ffd_pkg.sv -----
package ffd_pkg;

  // frame geometry
  localparam int FRAME_BYTES = 133;
  localparam int ADDR_W      = 8;
  localparam int FIELDS      = 18;
  localparam int FIELD_W     = 5;

  // fixed frame markers and positions
  localparam logic [7:0] HDR_A            = 8'hFA;
  localparam logic [7:0] HDR_B            = 8'hAF;
  localparam logic [7:0] TAIL_A           = 8'hFB;
  localparam logic [7:0] TAIL_B           = 8'hBF;
  localparam logic [7:0] CHK_POS          = 8'd130;
  localparam logic [7:0] TAIL_A_POS       = 8'd131;
  localparam logic [7:0] LAST_POS         = 8'd132;
  localparam logic [7:0] SENSOR_FLAGS_POS = 8'd115;
  localparam logic [7:0] NAV_MODE_POS     = 8'd129;
  localparam logic [7:0] SCAN_START       = 8'd2;
  localparam logic [FIELD_W-1:0] LAST_FIELD = 5'd17;

  // result status codes
  localparam logic [1:0] STAT_NONE   = 2'd0;
  localparam logic [1:0] STAT_VALID  = 2'd1;
  localparam logic [1:0] STAT_REJECT = 2'd2;

  // sequencer states
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CHECK = 7'b0000010,
    ST_FETCH = 7'b0000100,
    ST_LOAD  = 7'b0001000,
    ST_REJ   = 7'b0010000,
    ST_SCAN  = 7'b0100000,
    ST_COPY  = 7'b1000000
  } state_t;

  // first byte of each decoded field
  function automatic logic [7:0] field_offset(input logic [FIELD_W-1:0] k);
    logic [7:0] off;
    case (k)
      5'd0:    off = 8'd2;
      5'd1:    off = 8'd6;
      5'd2:    off = 8'd10;
      5'd3:    off = 8'd14;
      5'd4:    off = 8'd18;
      5'd5:    off = 8'd22;
      5'd6:    off = 8'd26;
      5'd7:    off = 8'd30;
      5'd8:    off = 8'd34;
      5'd9:    off = 8'd38;
      5'd10:   off = 8'd42;
      5'd11:   off = 8'd46;
      5'd12:   off = 8'd99;
      5'd13:   off = 8'd103;
      5'd14:   off = 8'd107;
      5'd15:   off = 8'd111;
      5'd16:   off = SENSOR_FLAGS_POS;
      5'd17:   off = NAV_MODE_POS;
      default: off = 8'd0;
    endcase
    return off;
  endfunction

endpackage

// ----- design/fixed_frame_deframer_xor_check.sv -----
// channel   direction  handshake            payload
// input     in         in_valid / in_stall   rx_byte
// output    out        out_valid / out_stall frame_status, field_index, field_value,
//                                            last_of_run
//
// the next byte is taken once the status result of a plain byte can leave.
// a completed frame is checked by one pass over the frame memory read port, then
// each word field and each flag field is gathered and sent, or the rejection is sent
// and a resync scan follows, with a move if a header byte is found, plus output stalls.
// rst is synchronous and clears control state; the frame memory is not cleared.
// in_stall is high during check, decode and resync and while a result is stalled.
module fixed_frame_deframer_xor_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  frame_status,
  output logic [4:0]  field_index,
  output logic [31:0] field_value,
  output logic        last_of_run
);

  localparam logic [7:0] FRAME_LEN = 8'(ffd_pkg::FRAME_BYTES);

  // frame memory
  logic [7:0] mem [0:ffd_pkg::FRAME_BYTES-1];
  logic       we;
  logic [7:0] wa;
  logic [7:0] wd;
  logic [7:0] ra;
  logic [7:0] rd_data;

  ffd_pkg::state_t state, state_next;
  logic [7:0]  fill_count, fill_count_next;
  logic [7:0]  cnt, cnt_next;
  logic [7:0]  base, base_next;
  logic        pend, pend_next;
  logic [7:0]  pend_addr, pend_addr_next;
  logic [7:0]  xacc, xacc_next;
  logic        ok, ok_next;
  logic [4:0]  fld, fld_next;
  logic [2:0]  jcnt, jcnt_next;
  logic [2:0]  ccnt, ccnt_next;
  logic [31:0] word, word_next;
  logic        out_valid_next;
  logic [1:0]  frame_status_next;
  logic [4:0]  field_index_next;
  logic [31:0] field_value_next;
  logic        last_of_run_next;

  logic       in_acc;
  logic       out_free;
  logic       issue;
  logic       is_flag;
  logic [2:0] nbytes;
  logic       byte_ok;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ffd_pkg::ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign is_flag  = fld[4];
  assign nbytes   = is_flag ? 3'd1 : 3'd4;

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  // per-position frame check on returned data
  always_comb begin
    case (pend_addr)
      8'd0:                byte_ok = (rd_data == ffd_pkg::HDR_A);
      8'd1:                byte_ok = (rd_data == ffd_pkg::HDR_B);
      ffd_pkg::CHK_POS:    byte_ok = (rd_data == xacc);
      ffd_pkg::TAIL_A_POS: byte_ok = (rd_data == ffd_pkg::TAIL_A);
      ffd_pkg::LAST_POS:   byte_ok = (rd_data == ffd_pkg::TAIL_B);
      default:             byte_ok = 1'b1;
    endcase
  end

  // sequencer
  always_comb begin
    state_next        = state;
    fill_count_next   = fill_count;
    cnt_next          = cnt;
    base_next         = base;
    pend_addr_next    = pend_addr;
    xacc_next         = xacc;
    ok_next           = ok;
    fld_next          = fld;
    jcnt_next         = jcnt;
    ccnt_next         = ccnt;
    word_next         = word;
    out_valid_next    = out_valid && out_stall;
    frame_status_next = frame_status;
    field_index_next  = field_index;
    field_value_next  = field_value;
    last_of_run_next  = last_of_run;
    we                = 1'b0;
    wa                = fill_count;
    wd                = rx_byte;
    ra                = 8'd0;
    issue             = 1'b0;

    case (state)
      ffd_pkg::ST_IDLE: begin
        if (in_acc) begin
          // plain status unless this byte completes a frame
          out_valid_next    = 1'b1;
          frame_status_next = ffd_pkg::STAT_NONE;
          field_index_next  = 5'd0;
          field_value_next  = 32'd0;
          last_of_run_next  = 1'b1;
          if (fill_count == 8'd0) begin
            if (rx_byte == ffd_pkg::HDR_A) begin
              we              = 1'b1;
              fill_count_next = 8'd1;
            end
          end else if (fill_count == 8'd1) begin
            if (rx_byte == ffd_pkg::HDR_B) begin
              we              = 1'b1;
              fill_count_next = 8'd2;
            end else if (rx_byte == ffd_pkg::HDR_A) begin
              we              = 1'b1;
              wa              = 8'd0;
              fill_count_next = 8'd1;
            end else begin
              fill_count_next = 8'd0;
            end
          end else if (fill_count >= FRAME_LEN) begin
            fill_count_next = 8'd0;
          end else begin
            we              = 1'b1;
            fill_count_next = fill_count + 8'd1;
            if (fill_count == ffd_pkg::LAST_POS) begin
              out_valid_next = out_valid && out_stall;
              state_next     = ffd_pkg::ST_CHECK;
              cnt_next       = 8'd0;
              xacc_next      = 8'd0;
              ok_next        = 1'b1;
            end
          end
        end
      end

      ffd_pkg::ST_CHECK: begin
        // walk all bytes: header, xor, checksum, tail
        if (cnt < FRAME_LEN) begin
          issue    = 1'b1;
          ra       = cnt;
          cnt_next = cnt + 8'd1;
        end
        if (pend) begin
          if (pend_addr < ffd_pkg::CHK_POS) begin
            xacc_next = xacc ^ rd_data;
          end
          ok_next = ok && byte_ok;
          if (pend_addr == ffd_pkg::LAST_POS) begin
            if (ok && byte_ok) begin
              state_next      = ffd_pkg::ST_FETCH;
              fill_count_next = 8'd0;
              fld_next        = 5'd0;
              jcnt_next       = 3'd0;
              ccnt_next       = 3'd0;
            end else begin
              state_next = ffd_pkg::ST_REJ;
            end
          end
        end
      end

      ffd_pkg::ST_FETCH: begin
        // gather the bytes of one field, lowest first
        if (jcnt < nbytes) begin
          issue     = 1'b1;
          ra        = ffd_pkg::field_offset(fld) + {5'd0, jcnt};
          jcnt_next = jcnt + 3'd1;
        end
        if (pend) begin
          word_next = is_flag ? {24'd0, rd_data} : {rd_data, word[31:8]};
          ccnt_next = ccnt + 3'd1;
          if (ccnt == nbytes - 3'd1) begin
            state_next = ffd_pkg::ST_LOAD;
          end
        end
      end

      ffd_pkg::ST_LOAD: begin
        if (out_free) begin
          out_valid_next    = 1'b1;
          frame_status_next = ffd_pkg::STAT_VALID;
          field_index_next  = fld;
          field_value_next  = word;
          last_of_run_next  = (fld == ffd_pkg::LAST_FIELD);
          if (fld == ffd_pkg::LAST_FIELD) begin
            state_next = ffd_pkg::ST_IDLE;
          end else begin
            state_next = ffd_pkg::ST_FETCH;
            fld_next   = fld + 5'd1;
            jcnt_next  = 3'd0;
            ccnt_next  = 3'd0;
          end
        end
      end

      ffd_pkg::ST_REJ: begin
        if (out_free) begin
          out_valid_next    = 1'b1;
          frame_status_next = ffd_pkg::STAT_REJECT;
          field_index_next  = 5'd0;
          field_value_next  = 32'd0;
          last_of_run_next  = 1'b1;
          state_next        = ffd_pkg::ST_SCAN;
          cnt_next          = ffd_pkg::SCAN_START;
        end
      end

      ffd_pkg::ST_SCAN: begin
        // look for a new header start from position 2
        if (cnt < FRAME_LEN) begin
          issue    = 1'b1;
          ra       = cnt;
          cnt_next = cnt + 8'd1;
        end
        if (pend) begin
          if (rd_data == ffd_pkg::HDR_A) begin
            // restart reads at the found byte for the move
            issue      = 1'b1;
            ra         = pend_addr;
            cnt_next   = pend_addr + 8'd1;
            base_next  = pend_addr;
            state_next = ffd_pkg::ST_COPY;
          end else if (pend_addr == ffd_pkg::LAST_POS) begin
            fill_count_next = 8'd0;
            state_next      = ffd_pkg::ST_IDLE;
          end
        end
      end

      ffd_pkg::ST_COPY: begin
        // move the remainder to the front, one byte a cycle
        if (cnt < FRAME_LEN) begin
          issue    = 1'b1;
          ra       = cnt;
          cnt_next = cnt + 8'd1;
        end
        if (pend) begin
          we = 1'b1;
          wa = pend_addr - base;
          wd = rd_data;
          if (pend_addr == ffd_pkg::LAST_POS) begin
            fill_count_next = FRAME_LEN - base;
            state_next      = ffd_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_next = ffd_pkg::ST_IDLE;
      end
    endcase

    pend_next      = issue;
    pend_addr_next = ra;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ffd_pkg::ST_IDLE;
      fill_count <= 8'd0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      pend       <= pend_next;
      out_valid  <= out_valid_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt          <= cnt_next;
    base         <= base_next;
    pend_addr    <= pend_addr_next;
    xacc         <= xacc_next;
    ok           <= ok_next;
    fld          <= fld_next;
    jcnt         <= jcnt_next;
    ccnt         <= ccnt_next;
    word         <= word_next;
    frame_status <= frame_status_next;
    field_index  <= field_index_next;
    field_value  <= field_value_next;
    last_of_run  <= last_of_run_next;
  end

  // checks
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FRAME_LEN)
    else $error("fill count beyond frame length");

  a_reject_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status == ffd_pkg::STAT_REJECT |->
      field_index == 5'd0 && field_value == 32'd0 && last_of_run)
    else $error("rejection result not clean");

  a_plain_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status == ffd_pkg::STAT_NONE |->
      field_index == 5'd0 && field_value == 32'd0 && last_of_run)
    else $error("plain status result not clean");

  a_valid_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status == ffd_pkg::STAT_VALID |->
      last_of_run == (field_index == ffd_pkg::LAST_FIELD))
    else $error("last mark not on final field");

endmodule
